/* rtl/nvm_pkg.sv */
// ----------------------------------------------------------------------------
// Nearest value match pool package
// Shared constants, selection codes and the command and status structures
// exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package nvm_pkg;

   localparam int POOL_DEPTH    = 4096;
   localparam int ADDR_W        = $clog2(POOL_DEPTH);
   localparam int CNT_W         = $clog2(POOL_DEPTH + 1);
   localparam int VAL_W         = 31;
   localparam int TOT_W         = 20;
   localparam int TOTAL_MODULUS = 1000000;
   localparam int MOD_STEPS     = 12;
   localparam int K_W           = $clog2(MOD_STEPS);

   typedef enum logic [2:0] {
      RD_MID  = 3'd0,
      RD_PRED = 3'd1,
      RD_SUCC = 3'd2,
      RD_CUR  = 3'd3,
      RD_CURM = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CUR  = 2'd0,
      WR_CURM = 2'd1,
      WR_POS  = 2'd2
   } wr_sel_type;

   typedef struct packed {
      logic       load;
      logic       srch_step;
      logic       mark_ovf;
      logic       ins_start;
      logic       cap_pred;
      logic       pick;
      logic       cur_inc;
      logic       cur_dec;
      logic       ins_done;
      logic       rem_done;
      logic       mod_step;
      logic       finish;
      logic       wr_en;
      wr_sel_type wr_sel;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic srch_done;
      logic is_insert;
      logic is_full;
      logic ins_more;
      logic rem_more;
      logic mod_last;
      logic out_busy;
   } status_type;

endpackage

/* rtl/nvm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nvm_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nvm_ctrl.sv */
// ----------------------------------------------------------------------------
// Nearest value match pool controller
// Sequences the search, insert shift, removal shift and modulo reduction.
// ----------------------------------------------------------------------------
module nvm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  nvm_pkg::status_type status,
   output nvm_pkg::cmd_type    cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_SRCH   = 13'b0000000000010,
      S_SCMP   = 13'b0000000000100,
      S_DECIDE = 13'b0000000001000,
      S_IRD    = 13'b0000000010000,
      S_IWR    = 13'b0000000100000,
      S_MRD    = 13'b0000001000000,
      S_MSEL   = 13'b0000010000000,
      S_RRD    = 13'b0000100000000,
      S_RWR    = 13'b0001000000000,
      S_MOD    = 13'b0010000000000,
      S_FIN    = 13'b0100000000000,
      S_SPARE  = 13'b1000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = nvm_pkg::RD_MID;
      cmd.wr_sel = nvm_pkg::WR_CUR;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            if (status.srch_done) begin
               state_in = S_DECIDE;
            end else begin
               cmd.rd_sel = nvm_pkg::RD_MID;
               state_in   = S_SCMP;
            end
         end
         S_SCMP: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SRCH;
         end
         S_DECIDE: begin
            if (status.is_insert) begin
               if (status.is_full) begin
                  cmd.mark_ovf = 1'b1;
                  state_in     = S_FIN;
               end else begin
                  cmd.ins_start = 1'b1;
                  state_in      = S_IRD;
               end
            end else begin
               cmd.rd_sel = nvm_pkg::RD_PRED;
               state_in   = S_MRD;
            end
         end
         S_IRD: begin
            if (status.ins_more) begin
               cmd.rd_sel = nvm_pkg::RD_CURM;
               state_in   = S_IWR;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.wr_sel   = nvm_pkg::WR_POS;
               cmd.ins_done = 1'b1;
               state_in     = S_FIN;
            end
         end
         S_IWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = nvm_pkg::WR_CUR;
            cmd.cur_dec = 1'b1;
            state_in    = S_IRD;
         end
         S_MRD: begin
            cmd.cap_pred = 1'b1;
            cmd.rd_sel   = nvm_pkg::RD_SUCC;
            state_in     = S_MSEL;
         end
         S_MSEL: begin
            cmd.pick = 1'b1;
            state_in = S_RRD;
         end
         S_RRD: begin
            if (status.rem_more) begin
               cmd.rd_sel = nvm_pkg::RD_CUR;
               state_in   = S_RWR;
            end else begin
               cmd.rem_done = 1'b1;
               state_in     = S_MOD;
            end
         end
         S_RWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = nvm_pkg::WR_CURM;
            cmd.cur_inc = 1'b1;
            state_in    = S_RRD;
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/nvm_dp.sv */
// ----------------------------------------------------------------------------
// Nearest value match pool datapath
// Holds the request, the pool bookkeeping, the sorted value memory, the
// search bounds, the shift cursor, the modulo reducer and the result register.
// ----------------------------------------------------------------------------
module nvm_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_side,
   input  logic [nvm_pkg::VAL_W-1:0]   req_key_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [nvm_pkg::VAL_W-1:0]   rsp_distance,
   output logic                        rsp_matched,
   output logic [nvm_pkg::TOT_W-1:0]   rsp_running_total,
   output logic                        rsp_overflow,
   input  nvm_pkg::cmd_type            cmd,
   output nvm_pkg::status_type         status
);

   localparam int AW = nvm_pkg::ADDR_W;
   localparam int CW = nvm_pkg::CNT_W;
   localparam int VW = nvm_pkg::VAL_W;
   localparam int TW = nvm_pkg::TOT_W;
   localparam int KW = nvm_pkg::K_W;

   logic          side_ff;
   logic [VW-1:0] key_ff;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pside_ff, pside_in;
   logic [TW-1:0] total_ff, total_in;
   logic [VW-1:0] pred_ff;
   logic [VW-1:0] dist_ff, dist_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [KW-1:0] k_ff, k_in;
   logic          matched_ff, matched_in;
   logic          ovf_ff, ovf_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0] out_dist_ff;
   logic          out_matched_ff;
   logic [TW-1:0] out_total_ff;
   logic          out_ovf_ff;

   logic [CW:0]   sum_lh;
   logic [CW-1:0] mid;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [VW-1:0] wr_data;
   logic [VW-1:0] q;
   logic          has_pred, has_succ;
   logic [VW-1:0] dp_val, ds_val;
   logic          take_pred;
   logic [VW+1:0] mod_sub;
   logic [TW:0]   total_sum;

   nvm_ram #(
      .WIDTH (VW),
      .DEPTH (nvm_pkg::POOL_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (q)
   );

   assign sum_lh = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid    = sum_lh[CW:1];

   always_comb begin
      unique case (cmd.rd_sel)
         nvm_pkg::RD_MID:  rd_addr = mid[AW-1:0];
         nvm_pkg::RD_PRED: rd_addr = AW'(lo_ff - CW'(1));
         nvm_pkg::RD_SUCC: rd_addr = lo_ff[AW-1:0];
         nvm_pkg::RD_CUR:  rd_addr = cur_ff[AW-1:0];
         nvm_pkg::RD_CURM: rd_addr = AW'(cur_ff - CW'(1));
         default:          rd_addr = mid[AW-1:0];
      endcase
   end

   always_comb begin
      unique case (cmd.wr_sel)
         nvm_pkg::WR_CUR: begin
            wr_addr = cur_ff[AW-1:0];
            wr_data = q;
         end
         nvm_pkg::WR_CURM: begin
            wr_addr = AW'(cur_ff - CW'(1));
            wr_data = q;
         end
         nvm_pkg::WR_POS: begin
            wr_addr = lo_ff[AW-1:0];
            wr_data = key_ff;
         end
         default: begin
            wr_addr = cur_ff[AW-1:0];
            wr_data = q;
         end
      endcase
   end

   assign has_pred  = (lo_ff != '0);
   assign has_succ  = (lo_ff < count_ff);
   assign dp_val    = key_ff - pred_ff;
   assign ds_val    = q - key_ff;
   assign take_pred = has_pred && (!has_succ || (dp_val <= ds_val));

   assign mod_sub   = (VW+2)'(nvm_pkg::TOTAL_MODULUS) << k_ff;
   assign total_sum = {1'b0, total_ff} + (TW+1)'(rem_ff);

   assign status.srch_done = (lo_ff >= hi_ff);
   assign status.is_insert = (count_ff == '0) || (side_ff == pside_ff);
   assign status.is_full   = (count_ff == CW'(nvm_pkg::POOL_DEPTH));
   assign status.ins_more  = (cur_ff > lo_ff);
   assign status.rem_more  = (cur_ff < count_ff);
   assign status.mod_last  = (k_ff == '0);
   assign status.out_busy  = rsp_valid_ff && rsp_stall;

   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      pside_in     = pside_ff;
      total_in     = total_ff;
      dist_in      = dist_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      matched_in   = matched_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load) begin
         lo_in      = '0;
         hi_in      = count_ff;
         dist_in    = '0;
         rem_in     = '0;
         matched_in = 1'b0;
         ovf_in     = 1'b0;
      end
      if (cmd.srch_step) begin
         if (q <= key_ff) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.mark_ovf) begin
         ovf_in   = 1'b1;
         pside_in = side_ff;
      end
      if (cmd.ins_start) begin
         cur_in   = count_ff;
         pside_in = side_ff;
      end
      if (cmd.pick) begin
         matched_in = 1'b1;
         k_in       = KW'(nvm_pkg::MOD_STEPS - 1);
         if (take_pred) begin
            dist_in = dp_val;
            rem_in  = dp_val;
            cur_in  = lo_ff;
         end else begin
            dist_in = ds_val;
            rem_in  = ds_val;
            cur_in  = lo_ff + CW'(1);
         end
      end
      if (cmd.cur_inc) begin
         cur_in = cur_ff + CW'(1);
      end
      if (cmd.cur_dec) begin
         cur_in = cur_ff - CW'(1);
      end
      if (cmd.ins_done) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.rem_done) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.mod_step) begin
         if ({2'b00, rem_ff} >= mod_sub) begin
            rem_in = VW'({2'b00, rem_ff} - mod_sub);
         end
         k_in = k_ff - KW'(1);
      end
      if (cmd.finish) begin
         if (total_sum >= (TW+1)'(nvm_pkg::TOTAL_MODULUS)) begin
            total_in = TW'(total_sum - (TW+1)'(nvm_pkg::TOTAL_MODULUS));
         end else begin
            total_in = total_sum[TW-1:0];
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pside_ff     <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pside_ff     <= pside_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         side_ff <= req_side;
         key_ff  <= req_key_value;
      end
      if (cmd.cap_pred) begin
         pred_ff <= q;
      end
      if (cmd.finish) begin
         out_dist_ff    <= dist_ff;
         out_matched_ff <= matched_ff;
         out_total_ff   <= total_in;
         out_ovf_ff     <= ovf_ff;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      cur_ff     <= cur_in;
      dist_ff    <= dist_in;
      rem_ff     <= rem_in;
      k_ff       <= k_in;
      matched_ff <= matched_in;
      ovf_ff     <= ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance      = out_dist_ff;
   assign rsp_matched       = out_matched_ff;
   assign rsp_running_total = out_total_ff;
   assign rsp_overflow      = out_ovf_ff;

endmodule

/* rtl/nearest_value_match_pool_unit.sv */
// ----------------------------------------------------------------------------
// Nearest value match pool
// Sorted pool of waiting values; a request is stored or matched to the
// nearest stored value, with a running total of distances.
// ----------------------------------------------------------------------------
// The binary search over the pool takes up to 13 steps; an insert or a removal
// then moves entries one at a time through the value memory, and a match ends
// with a modulo reduction of the distance before the control finishes.
// Only one request is taken at a time; the shift through the single read port
// of the value memory sets the rate for a large pool.
// Reset clears the pool count, pool side, running total and result valid.
// ----------------------------------------------------------------------------
module nearest_value_match_pool_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_side,
   input  logic [nvm_pkg::VAL_W-1:0] req_key_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [nvm_pkg::VAL_W-1:0] rsp_distance,
   output logic                      rsp_matched,
   output logic [nvm_pkg::TOT_W-1:0] rsp_running_total,
   output logic                      rsp_overflow
);

   nvm_pkg::cmd_type    cmd;
   nvm_pkg::status_type status;

   nvm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   nvm_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_side          (req_side),
      .req_key_value     (req_key_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_distance      (rsp_distance),
      .rsp_matched       (rsp_matched),
      .rsp_running_total (rsp_running_total),
      .rsp_overflow      (rsp_overflow),
      .cmd               (cmd),
      .status            (status)
   );

endmodule

/* rtl/nvm_checker.sv */
// ----------------------------------------------------------------------------
// Nearest value match pool checker
// Port level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module nvm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [nvm_pkg::VAL_W-1:0] rsp_distance,
   input logic                      rsp_matched,
   input logic [nvm_pkg::TOT_W-1:0] rsp_running_total,
   input logic                      rsp_overflow
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result valid after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance)
         && $stable(rsp_running_total))
      else $error("Stalled transfer changed.");

   a_store_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_distance == '0)
      else $error("Stored request has a nonzero distance.");

   a_ovf_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_matched)
      else $error("Overflow on a match.");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_running_total < nvm_pkg::TOT_W'(nvm_pkg::TOTAL_MODULUS))
      else $error("Running total out of range.");

endmodule

bind nearest_value_match_pool_unit nvm_checker u_nvm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_distance      (rsp_distance),
   .rsp_matched       (rsp_matched),
   .rsp_running_total (rsp_running_total),
   .rsp_overflow      (rsp_overflow)
);
